// File: design/lru_key_value_cache_assert.svh
// lru_key_value_cache_assert.svh: assertion macros for the LRU cache checker.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// Checked only while out of reset
`define LKV_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define LKV_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/lkv_pkg.sv
// lkv_pkg.sv: sizes, widths and sequencer states for the LRU key-value cache.
// No dependencies; used by lru_key_value_cache and lkv_checker.
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int IDX_BITS   = $clog2(ENTRIES);
	localparam int CNT_BITS   = $clog2(ENTRIES + 1);
	localparam int AGE_BITS   = IDX_BITS;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 32;
	localparam int CAP_BITS   = 5;
	// common width for capacity / fill compares
	localparam int CMP_BITS   = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} lkv_state_t;

endpackage

// File: design/lkv_ram.sv
// lkv_ram.sv: generic one-write, one-read RAM with registered read data.
// No dependencies.
module lkv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: design/lru_key_value_cache.sv
// lru_key_value_cache.sv: fully associative key-value cache, LRU replacement.
// Depends on lkv_pkg and lkv_ram (key and data stores).
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  input   | in_valid, in_ready, action, key, value | in
//  result  | out_valid, out_ready, hit, read_value  | out
//  config  | cfg_valid, cfg_ready, cfg_data         | in
//
// A beat is accepted, then scanned through the key RAM (one read per cycle, compare
// in the cycle after each read), and then written back. in_ready is high only in
// the idle state.
// The result sits in an output register; the write-back waits while it is full and out_ready is low.
// Reset clears valid bits, ages, fill count and sets capacity to 16.
module lru_key_value_cache (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             action,
	input  logic [lkv_pkg::KEY_BITS-1:0]     key,
	input  logic [lkv_pkg::VALUE_BITS-1:0]   value,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic                             hit,
	output logic [lkv_pkg::VALUE_BITS-1:0]   read_value,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lkv_pkg::CAP_BITS-1:0]     cfg_data
);

	lkv_pkg::lkv_state_t state_q, state_d;

	// latched request
	logic                               action_q;
	logic [lkv_pkg::KEY_BITS-1:0]       key_q;
	logic [lkv_pkg::VALUE_BITS-1:0]     value_q;

	// scan counter and compare stage
	logic [lkv_pkg::CNT_BITS-1:0]       scan_q;
	logic                               rd_v_s1;
	logic [lkv_pkg::IDX_BITS-1:0]       rd_idx_s1;

	// scan results
	logic                               found_v_q;
	logic [lkv_pkg::IDX_BITS-1:0]       found_idx_q;
	logic [lkv_pkg::VALUE_BITS-1:0]     data_q;
	logic                               free_v_q;
	logic [lkv_pkg::IDX_BITS-1:0]       free_idx_q;
	logic                               vict_v_q;
	logic [lkv_pkg::IDX_BITS-1:0]       vict_idx_q;
	logic [lkv_pkg::AGE_BITS-1:0]       oldest_q;

	// per-entry recency state
	logic                               valid_q [lkv_pkg::ENTRIES];
	logic [lkv_pkg::AGE_BITS-1:0]       age_q   [lkv_pkg::ENTRIES];
	logic [lkv_pkg::CNT_BITS-1:0]       fill_q;
	logic [lkv_pkg::CAP_BITS-1:0]       capacity_q;

	// result register
	logic                               out_valid_q;
	logic                               hit_q;
	logic [lkv_pkg::VALUE_BITS-1:0]     read_value_q;

	// RAM ports
	logic [lkv_pkg::KEY_BITS-1:0]       key_rdata;
	logic [lkv_pkg::VALUE_BITS-1:0]     data_rdata;
	logic                               key_we;
	logic                               data_we;
	logic [lkv_pkg::IDX_BITS-1:0]       waddr;
	logic [lkv_pkg::IDX_BITS-1:0]       raddr;

	// update decisions
	logic                               in_acc;
	logic                               scan_rd;
	logic                               scan_done;
	logic                               upd_go;
	logic [lkv_pkg::CMP_BITS-1:0]       cap_w;
	logic [lkv_pkg::CMP_BITS-1:0]       cap_eff;
	logic [lkv_pkg::CMP_BITS-1:0]       fill_w;
	logic                               do_insert;
	logic                               do_evict;
	logic                               touch_v;
	logic [lkv_pkg::IDX_BITS-1:0]       touch_idx;
	logic [lkv_pkg::AGE_BITS-1:0]       lim;

	assign in_ready  = (state_q == lkv_pkg::ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign scan_rd   = (state_q == lkv_pkg::ST_SCAN) &&
	                   (scan_q < lkv_pkg::CNT_BITS'(lkv_pkg::ENTRIES));
	assign scan_done = (state_q == lkv_pkg::ST_SCAN) &&
	                   (scan_q == lkv_pkg::CNT_BITS'(lkv_pkg::ENTRIES));
	assign upd_go    = (state_q == lkv_pkg::ST_UPDATE) && (!out_valid_q || out_ready);
	assign raddr     = scan_q[lkv_pkg::IDX_BITS-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			lkv_pkg::ST_IDLE: begin
				if (in_valid) state_d = lkv_pkg::ST_SCAN;
			end
			lkv_pkg::ST_SCAN: begin
				if (scan_done) state_d = lkv_pkg::ST_UPDATE;
			end
			lkv_pkg::ST_UPDATE: begin
				if (upd_go) state_d = lkv_pkg::ST_IDLE;
			end
			default: state_d = lkv_pkg::ST_IDLE;
		endcase
	end

	// request latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			action_q <= action;
			key_q    <= key;
			value_q  <= value;
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// scan counter and read-to-compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q  <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			if (in_acc) begin
				scan_q <= '0;
			end else if (scan_rd) begin
				scan_q <= scan_q + 1'b1;
			end
			rd_v_s1 <= scan_rd;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= raddr;
	end

	// shared compare: key match, free slot, oldest entry, one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_v_q <= 1'b0;
			free_v_q  <= 1'b0;
			vict_v_q  <= 1'b0;
		end else if (in_acc) begin
			found_v_q <= 1'b0;
			free_v_q  <= 1'b0;
			vict_v_q  <= 1'b0;
		end else if (rd_v_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!found_v_q && key_rdata == key_q) begin
					found_v_q <= 1'b1;
				end
				if (!vict_v_q || age_q[rd_idx_s1] > oldest_q) begin
					vict_v_q <= 1'b1;
				end
			end else if (!free_v_q) begin
				free_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			if (valid_q[rd_idx_s1]) begin
				if (!found_v_q && key_rdata == key_q) begin
					found_idx_q <= rd_idx_s1;
					data_q      <= data_rdata;
				end
				if (!vict_v_q || age_q[rd_idx_s1] > oldest_q) begin
					vict_idx_q <= rd_idx_s1;
					oldest_q   <= age_q[rd_idx_s1];
				end
			end else if (!free_v_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
	end

	// write-back decisions
	always_comb begin
		cap_w   = lkv_pkg::CMP_BITS'(capacity_q);
		fill_w  = lkv_pkg::CMP_BITS'(fill_q);
		cap_eff = cap_w;
		if (cap_w == '0) begin
			cap_eff = lkv_pkg::CMP_BITS'(1);
		end else if (cap_w > lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES)) begin
			cap_eff = lkv_pkg::CMP_BITS'(lkv_pkg::ENTRIES);
		end
		do_insert = !found_v_q && (action_q == lkv_pkg::ACT_PUT) &&
		            (fill_w < cap_eff) && free_v_q;
		do_evict  = !found_v_q && (action_q == lkv_pkg::ACT_PUT) &&
		            !do_insert && vict_v_q;
		touch_v   = found_v_q || do_evict;
		touch_idx = found_v_q ? found_idx_q : vict_idx_q;
		lim       = age_q[touch_idx];
		waddr     = do_insert ? free_idx_q : touch_idx;
		key_we    = upd_go && (do_insert || do_evict);
		data_we   = upd_go && (do_insert || do_evict ||
		            (found_v_q && action_q == lkv_pkg::ACT_PUT));
	end

	// valid bits, ages and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				valid_q[i] <= 1'b0;
				age_q[i]   <= '0;
			end
			fill_q <= '0;
		end else if (upd_go) begin
			for (int i = 0; i < lkv_pkg::ENTRIES; i++) begin
				if (do_insert) begin
					if (lkv_pkg::IDX_BITS'(i) == free_idx_q) begin
						valid_q[i] <= 1'b1;
						age_q[i]   <= '0;
					end else if (valid_q[i]) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end else if (touch_v) begin
					if (lkv_pkg::IDX_BITS'(i) == touch_idx) begin
						age_q[i] <= '0;
					end else if (valid_q[i] && age_q[i] < lim) begin
						age_q[i] <= age_q[i] + 1'b1;
					end
				end
			end
			if (do_insert) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go) begin
			hit_q        <= found_v_q;
			read_value_q <= (found_v_q && action_q == lkv_pkg::ACT_GET) ? data_q : '0;
		end
	end

	assign out_valid  = out_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;

	// key and data stores
	lkv_ram #(
		.WIDTH(lkv_pkg::KEY_BITS),
		.DEPTH(lkv_pkg::ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (key_rdata)
	);

	lkv_ram #(
		.WIDTH(lkv_pkg::VALUE_BITS),
		.DEPTH(lkv_pkg::ENTRIES)
	) u_data_ram (
		.clk   (clk),
		.we    (data_we),
		.waddr (waddr),
		.wdata (value_q),
		.raddr (raddr),
		.rdata (data_rdata)
	);

endmodule

// File: design/lkv_checker.sv
// lkv_checker.sv: port-level assertions for lru_key_value_cache, bound to the top.
// Depends on lkv_pkg and lru_key_value_cache_assert.svh.
`include "lru_key_value_cache_assert.svh"

module lkv_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic                             hit,
	input logic [lkv_pkg::VALUE_BITS-1:0]   read_value
);

	// a stalled result beat holds
	`LKV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hit) && $stable(read_value), "result changed while stalled")

	// a miss never carries data
	`LKV_ASSERT(a_miss_zero, out_valid && !hit |-> read_value == '0, "miss with nonzero read_value")

	// one beat at a time: busy right after an accepted beat
	`LKV_ASSERT(a_busy_after_acc, in_valid && in_ready |=> !in_ready, "ready right after an accepted beat")

	// a result appears only after a busy cycle
	`LKV_ASSERT(a_result_after_busy, $rose(out_valid) |-> $past(!in_ready), "result without preceding work")

	// reset empties the result register
	`LKV_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
